// ===== design/atns_pkg.sv =====
// Shared types, field widths and codes for the alarm table scheduler.
// No dependencies; design files other than atns_ram use it by scoped name.

package atns_pkg;

    localparam int MAX_ALARMS_DEF = 16;

    localparam int OP_W       = 2;
    localparam int INDEX_W    = 4;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int MODE_W     = 2;
    localparam int WEEKMASK_W = 8;
    localparam int WEEKDAY_W  = 3;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int SLOT_W     = 5;
    localparam int KEY_W      = HOUR_W + MINUTE_W;

    localparam logic [SLOT_W-1:0] NO_SLOT = '1;

    localparam logic [OP_W-1:0] OP_SET   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_SCHED = 2'd2;
    localparam logic [OP_W-1:0] OP_DUP   = 2'd3;

    // The spare mode code is stored as given and behaves like off.
    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ONESHOT = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [HOUR_W-1:0]     hour;
        logic [MINUTE_W-1:0]   minute;
        logic [MODE_W-1:0]     mode;
        logic [WEEKMASK_W-1:0] weekmask;
    } entry_t;

    typedef struct packed {
        logic [OP_W-1:0]       op;
        logic [INDEX_W-1:0]    entry_index;
        logic [HOUR_W-1:0]     alarm_hour;
        logic [MINUTE_W-1:0]   alarm_minute;
        logic [MODE_W-1:0]     alarm_mode;
        logic [WEEKMASK_W-1:0] alarm_weekmask;
        logic [HOUR_W-1:0]     now_hour;
        logic [MINUTE_W-1:0]   now_minute;
        logic [WEEKDAY_W-1:0]  now_weekday;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic                  arm_valid;
        logic [INDEX_W-1:0]    arm_index;
        logic [HOUR_W-1:0]     arm_hour;
        logic [MINUTE_W-1:0]   arm_minute;
        logic [WEEKMASK_W-1:0] arm_weekmask;
        logic                  duplicate;
        logic                  one_shot_expired;
        logic [COUNT_W-1:0]    alarm_count;
    } res_t;

    typedef struct packed {
        logic              start;
        logic              en;
        logic [SLOT_W-1:0] slot;
    } scan_ctl_t;

    typedef struct packed {
        logic              found_later;
        logic [SLOT_W-1:0] later_slot;
        entry_t            later_entry;
        logic [SLOT_W-1:0] any_slot;
        entry_t            any_entry;
        logic              dup;
    } scan_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET,
        S_SHIFT,
        S_SCAN,
        S_ARM,
        S_EXP_RD,
        S_EXP_CHK,
        S_DONE
    } state_t;

endpackage

// ===== design/atns_cmd_if.sv =====
// Command channel of the alarm table scheduler: valid/ready plus the command fields.
// Depends on atns_pkg for the field widths.

interface atns_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [atns_pkg::OP_W-1:0]       op;
    logic [atns_pkg::INDEX_W-1:0]    entry_index;
    logic [atns_pkg::HOUR_W-1:0]     alarm_hour;
    logic [atns_pkg::MINUTE_W-1:0]   alarm_minute;
    logic [atns_pkg::MODE_W-1:0]     alarm_mode;
    logic [atns_pkg::WEEKMASK_W-1:0] alarm_weekmask;
    logic [atns_pkg::HOUR_W-1:0]     now_hour;
    logic [atns_pkg::MINUTE_W-1:0]   now_minute;
    logic [atns_pkg::WEEKDAY_W-1:0]  now_weekday;

    modport source (
        output valid, op, entry_index, alarm_hour, alarm_minute, alarm_mode,
               alarm_weekmask, now_hour, now_minute, now_weekday,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, alarm_hour, alarm_minute, alarm_mode,
               alarm_weekmask, now_hour, now_minute, now_weekday,
        output ready
    );
endinterface

// ===== design/atns_rsp_if.sv =====
// Response channel of the alarm table scheduler: valid/ready plus the result fields.
// Depends on atns_pkg for the field widths.

interface atns_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [atns_pkg::STATUS_W-1:0]   status;
    logic                            arm_valid;
    logic [atns_pkg::INDEX_W-1:0]    arm_index;
    logic [atns_pkg::HOUR_W-1:0]     arm_hour;
    logic [atns_pkg::MINUTE_W-1:0]   arm_minute;
    logic [atns_pkg::WEEKMASK_W-1:0] arm_weekmask;
    logic                            duplicate;
    logic                            one_shot_expired;
    logic [atns_pkg::COUNT_W-1:0]    alarm_count;

    modport source (
        output valid, status, arm_valid, arm_index, arm_hour, arm_minute,
               arm_weekmask, duplicate, one_shot_expired, alarm_count,
        input  ready
    );
    modport sink (
        input  valid, status, arm_valid, arm_index, arm_hour, arm_minute,
               arm_weekmask, duplicate, one_shot_expired, alarm_count,
        output ready
    );
endinterface

// ===== design/alarm_table_next_alarm_scheduler.sv =====
// Top level of the alarm table scheduler: sequencer, table RAM and compare unit.
// Depends on atns_pkg, atns_cmd_if, atns_rsp_if, atns_ram and atns_scan.
//
// Usage: each transaction on cmd carries one command (set, delete, schedule
// or duplicate check) together with the current time; each command yields
// exactly one transaction on rsp with status, arming data, the duplicate flag,
// the expired one-shot flag and the table size after the command.
// The block works on one command at a time and keeps cmd.ready low until the
// sequencer returns to idle. A set passes through the set state, a delete
// through the shift state that moves the entries above it down, and a schedule
// or duplicate check through the scan and arm states; a failed delete or a
// schedule on an empty table skips these. Every command then passes the expiry
// read, expiry check and done states before the sequencer returns to idle.
// The table RAM has one read port with a registered output: the shift of a
// delete and the search of a schedule or duplicate check visit one entry per
// cycle, the search feeding each entry to the shared compare unit.
// A finished response sits in an output register, so the next command is
// accepted while it waits; if rsp.ready stays low, the following command
// stops in its final state until the register frees up.
// Reset empties the table and forgets the armed and pending slots. The RAM
// contents are not cleared, since no entry is read before it has been written.

module alarm_table_next_alarm_scheduler #(
    parameter int MAX_ALARMS = atns_pkg::MAX_ALARMS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    atns_cmd_if.sink    cmd,
    atns_rsp_if.source  rsp
);

    localparam int ADDR_W = $clog2(MAX_ALARMS);
    localparam int CNT_W  = $clog2(MAX_ALARMS + 1);
    localparam logic [atns_pkg::SLOT_W-1:0] MAX_SLOT = atns_pkg::SLOT_W'(MAX_ALARMS);

    // Sequencer and table bookkeeping.
    atns_pkg::state_t                state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [atns_pkg::SLOT_W-1:0]     last_armed_reg, last_armed_next;
    logic [atns_pkg::SLOT_W-1:0]     pending_reg, pending_next;
    logic                            rd_vld_reg, rd_vld_next;
    logic                            out_valid_reg, out_valid_next;

    // Payload registers.
    atns_pkg::cmd_t                  cmd_reg, cmd_next;
    atns_pkg::res_t                  res_reg, res_next;
    atns_pkg::res_t                  out_reg, out_next;
    logic [atns_pkg::SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [atns_pkg::SLOT_W-1:0]     rd_slot_reg, rd_slot_next;

    // Table RAM port.
    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    atns_pkg::entry_t                ram_wdata;
    logic [ADDR_W-1:0]               ram_raddr;
    atns_pkg::entry_t                ram_rdata;

    // Compare unit port.
    atns_pkg::scan_ctl_t             scan_ctl;
    atns_pkg::scan_res_t             scan_res;

    logic [atns_pkg::SLOT_W-1:0]     count_slot;
    logic [atns_pkg::SLOT_W-1:0]     cmd_in_slot;
    logic [atns_pkg::SLOT_W-1:0]     cmd_reg_slot;
    logic [atns_pkg::SLOT_W-1:0]     prev_slot;
    logic [atns_pkg::SLOT_W-1:0]     chosen_slot;
    atns_pkg::entry_t                chosen_entry;
    logic [atns_pkg::KEY_W-1:0]      now_key;
    logic [atns_pkg::KEY_W-1:0]      pend_key;
    logic                            rd_more;
    logic                            walk_done;
    logic                            del_bad;
    logic                            sched_empty;
    logic                            set_bad;
    logic                            pend_ok;
    logic                            out_free;
    logic                            cmd_fire;

    assign count_slot   = atns_pkg::SLOT_W'(count_reg);
    assign cmd_in_slot  = atns_pkg::SLOT_W'(cmd.entry_index);
    assign cmd_reg_slot = atns_pkg::SLOT_W'(cmd_reg.entry_index);
    assign prev_slot    = rd_slot_reg - atns_pkg::SLOT_W'(1);

    // The walk issues one read per cycle while entries remain and ends once
    // the last read's data has been consumed.
    assign rd_more   = ptr_reg < count_slot;
    assign walk_done = !rd_more && !rd_vld_reg;

    assign del_bad     = cmd_in_slot >= count_slot;
    assign sched_empty = (count_reg == '0);
    assign set_bad     = (cmd_reg_slot > count_slot) || (cmd_reg_slot >= MAX_SLOT);
    assign pend_ok     = pending_reg < MAX_SLOT;

    assign now_key  = {cmd_reg.now_hour, cmd_reg.now_minute};
    assign pend_key = {ram_rdata.hour, ram_rdata.minute};

    // With no entry later than now, the earliest entry of the day is taken.
    assign chosen_slot  = scan_res.found_later ? scan_res.later_slot  : scan_res.any_slot;
    assign chosen_entry = scan_res.found_later ? scan_res.later_entry : scan_res.any_entry;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    atns_ram #(
        .WIDTH ($bits(atns_pkg::entry_t)),
        .DEPTH (MAX_ALARMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    atns_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .entry     (ram_rdata),
        .now_key   (now_key),
        .dup_key   ({cmd_reg.alarm_hour, cmd_reg.alarm_minute}),
        .skip_slot (cmd_reg_slot),
        .res       (scan_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            atns_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.op)
                        atns_pkg::OP_SET:   state_next = atns_pkg::S_SET;
                        atns_pkg::OP_DEL:   state_next = del_bad ? atns_pkg::S_EXP_RD
                                                                 : atns_pkg::S_SHIFT;
                        atns_pkg::OP_SCHED: state_next = sched_empty ? atns_pkg::S_EXP_RD
                                                                     : atns_pkg::S_SCAN;
                        atns_pkg::OP_DUP:   state_next = atns_pkg::S_SCAN;
                        default:            state_next = atns_pkg::S_IDLE;
                    endcase
                end
            end
            atns_pkg::S_SET:     state_next = atns_pkg::S_EXP_RD;
            atns_pkg::S_SHIFT:
            begin
                if (walk_done)
                begin
                    state_next = atns_pkg::S_EXP_RD;
                end
            end
            atns_pkg::S_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = atns_pkg::S_ARM;
                end
            end
            atns_pkg::S_ARM:     state_next = atns_pkg::S_EXP_RD;
            atns_pkg::S_EXP_RD:  state_next = atns_pkg::S_EXP_CHK;
            atns_pkg::S_EXP_CHK: state_next = atns_pkg::S_DONE;
            atns_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = atns_pkg::S_IDLE;
                end
            end
            default:             state_next = atns_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        count_next      = count_reg;
        last_armed_next = last_armed_reg;
        pending_next    = pending_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = 1'b0;
        rd_slot_next    = rd_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = cmd_reg_slot[ADDR_W-1:0];
        ram_wdata       = ram_rdata;
        ram_raddr       = ptr_reg[ADDR_W-1:0];
        scan_ctl        = '0;
        scan_ctl.slot   = rd_slot_reg;

        unique case (state_reg)
            atns_pkg::S_IDLE:
            begin
                if (cmd_fire)
                begin
                    cmd_next.op             = cmd.op;
                    cmd_next.entry_index    = cmd.entry_index;
                    cmd_next.alarm_hour     = cmd.alarm_hour;
                    cmd_next.alarm_minute   = cmd.alarm_minute;
                    cmd_next.alarm_mode     = cmd.alarm_mode;
                    cmd_next.alarm_weekmask = cmd.alarm_weekmask;
                    cmd_next.now_hour       = cmd.now_hour;
                    cmd_next.now_minute     = cmd.now_minute;
                    cmd_next.now_weekday    = cmd.now_weekday;
                    res_next                = '0;
                    scan_ctl.start          = 1'b1;
                    ptr_next                = '0;
                    if (cmd.op == atns_pkg::OP_DEL)
                    begin
                        // The shift starts by reading the entry above the deleted one.
                        ptr_next = cmd_in_slot + atns_pkg::SLOT_W'(1);
                        if (del_bad)
                        begin
                            res_next.status = atns_pkg::STAT_RANGE;
                        end
                    end
                    if ((cmd.op == atns_pkg::OP_SCHED) && sched_empty)
                    begin
                        res_next.status = atns_pkg::STAT_EMPTY;
                    end
                end
            end
            atns_pkg::S_SET:
            begin
                if (set_bad)
                begin
                    res_next.status = atns_pkg::STAT_RANGE;
                end
                else
                begin
                    ram_we           = 1'b1;
                    ram_wdata.hour   = cmd_reg.alarm_hour;
                    ram_wdata.minute = cmd_reg.alarm_minute;
                    if (cmd_reg.alarm_weekmask == '0)
                    begin
                        // An empty mask means a one-shot alarm for today.
                        ram_wdata.mode     = atns_pkg::MODE_ONESHOT;
                        ram_wdata.weekmask = atns_pkg::WEEKMASK_W'(1) << cmd_reg.now_weekday;
                    end
                    else
                    begin
                        ram_wdata.mode     = cmd_reg.alarm_mode;
                        ram_wdata.weekmask = cmd_reg.alarm_weekmask;
                    end
                    if (cmd_reg_slot == count_slot)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            atns_pkg::S_SHIFT:
            begin
                if (rd_more)
                begin
                    ptr_next     = ptr_reg + atns_pkg::SLOT_W'(1);
                    rd_vld_next  = 1'b1;
                    rd_slot_next = ptr_reg;
                end
                if (rd_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = prev_slot[ADDR_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if (walk_done)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            atns_pkg::S_SCAN:
            begin
                if (rd_more)
                begin
                    ptr_next     = ptr_reg + atns_pkg::SLOT_W'(1);
                    rd_vld_next  = 1'b1;
                    rd_slot_next = ptr_reg;
                end
                scan_ctl.en = rd_vld_reg;
            end
            atns_pkg::S_ARM:
            begin
                if (cmd_reg.op == atns_pkg::OP_DUP)
                begin
                    res_next.duplicate = scan_res.dup;
                end
                else
                begin
                    res_next.arm_index    = chosen_slot[atns_pkg::INDEX_W-1:0];
                    res_next.arm_hour     = chosen_entry.hour;
                    res_next.arm_minute   = chosen_entry.minute;
                    res_next.arm_weekmask = chosen_entry.weekmask;
                    if (chosen_slot != last_armed_reg)
                    begin
                        unique case (chosen_entry.mode)
                            atns_pkg::MODE_REPEAT:
                            begin
                                res_next.arm_valid = 1'b1;
                                pending_next       = atns_pkg::NO_SLOT;
                            end
                            atns_pkg::MODE_ONESHOT:
                            begin
                                // Arming a one-shot disables its entry.
                                res_next.arm_valid = 1'b1;
                                pending_next       = chosen_slot;
                                ram_we             = 1'b1;
                                ram_waddr          = chosen_slot[ADDR_W-1:0];
                                ram_wdata.hour     = chosen_entry.hour;
                                ram_wdata.minute   = chosen_entry.minute;
                                ram_wdata.mode     = atns_pkg::MODE_OFF;
                                ram_wdata.weekmask = '0;
                            end
                            default:
                            begin
                            end
                        endcase
                        last_armed_next = chosen_slot;
                    end
                end
            end
            atns_pkg::S_EXP_RD:
            begin
                ram_raddr = pend_ok ? pending_reg[ADDR_W-1:0] : '0;
            end
            atns_pkg::S_EXP_CHK:
            begin
                res_next.one_shot_expired = pend_ok && (now_key >= pend_key);
                res_next.alarm_count      = atns_pkg::COUNT_W'(count_reg);
            end
            atns_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= atns_pkg::S_IDLE;
            count_reg      <= '0;
            last_armed_reg <= atns_pkg::NO_SLOT;
            pending_reg    <= atns_pkg::NO_SLOT;
            rd_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_armed_reg <= last_armed_next;
            pending_reg    <= pending_next;
            rd_vld_reg     <= rd_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
        ptr_reg     <= ptr_next;
        rd_slot_reg <= rd_slot_next;
    end

    assign cmd.ready = (state_reg == atns_pkg::S_IDLE);

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_reg.status;
    assign rsp.arm_valid        = out_reg.arm_valid;
    assign rsp.arm_index        = out_reg.arm_index;
    assign rsp.arm_hour         = out_reg.arm_hour;
    assign rsp.arm_minute       = out_reg.arm_minute;
    assign rsp.arm_weekmask     = out_reg.arm_weekmask;
    assign rsp.duplicate        = out_reg.duplicate;
    assign rsp.one_shot_expired = out_reg.one_shot_expired;
    assign rsp.alarm_count      = out_reg.alarm_count;

endmodule

// ===== design/atns_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module atns_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/atns_scan.sv =====
// Shared compare unit: takes one table entry per cycle and keeps the earliest
// later-than-now entry, the earliest entry of the day and the duplicate flag.
// Depends on atns_pkg.

module atns_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  atns_pkg::scan_ctl_t           ctl,
    input  atns_pkg::entry_t              entry,
    input  logic [atns_pkg::KEY_W-1:0]    now_key,
    input  logic [atns_pkg::KEY_W-1:0]    dup_key,
    input  logic [atns_pkg::SLOT_W-1:0]   skip_slot,
    output atns_pkg::scan_res_t           res
);

    atns_pkg::scan_res_t res_reg;
    atns_pkg::scan_res_t res_next;
    logic                any_seen_reg;
    logic                any_seen_next;

    logic [atns_pkg::KEY_W-1:0] ent_key;
    logic [atns_pkg::KEY_W-1:0] any_key;
    logic [atns_pkg::KEY_W-1:0] later_key;
    logic                       take_any;
    logic                       take_later;
    logic                       is_dup;

    assign ent_key   = {entry.hour, entry.minute};
    assign any_key   = {res_reg.any_entry.hour, res_reg.any_entry.minute};
    assign later_key = {res_reg.later_entry.hour, res_reg.later_entry.minute};

    // Strict compares keep the lowest index on equal times.
    assign take_any   = !any_seen_reg || (ent_key < any_key);
    assign take_later = (ent_key > now_key) && (!res_reg.found_later || (ent_key < later_key));
    assign is_dup     = (ctl.slot != skip_slot) && (ent_key == dup_key);

    always_comb
    begin
        res_next      = res_reg;
        any_seen_next = any_seen_reg;
        if (ctl.start)
        begin
            res_next.found_later = 1'b0;
            res_next.dup         = 1'b0;
            any_seen_next        = 1'b0;
        end
        else if (ctl.en)
        begin
            if (take_any)
            begin
                res_next.any_slot  = ctl.slot;
                res_next.any_entry = entry;
                any_seen_next      = 1'b1;
            end
            if (take_later)
            begin
                res_next.found_later = 1'b1;
                res_next.later_slot  = ctl.slot;
                res_next.later_entry = entry;
            end
            if (is_dup)
            begin
                res_next.dup = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg      <= '0;
            any_seen_reg <= 1'b0;
        end
        else
        begin
            res_reg      <= res_next;
            any_seen_reg <= any_seen_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/atns_checker.sv =====
// Port-level assertions for the alarm table scheduler, bound to the top level.
// Depends on atns_pkg and alarm_table_next_alarm_scheduler.

module atns_checker #(
    parameter int MAX_ALARMS = atns_pkg::MAX_ALARMS_DEF
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cmd_valid,
    input logic                            cmd_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [atns_pkg::STATUS_W-1:0]   rsp_status,
    input logic                            rsp_arm_valid,
    input logic [atns_pkg::INDEX_W-1:0]    rsp_arm_index,
    input logic                            rsp_duplicate,
    input logic [atns_pkg::COUNT_W-1:0]    rsp_alarm_count
);

    // One command at a time: acceptance closes the command port.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted while the previous one is in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (int'(rsp_alarm_count) <= MAX_ALARMS))
        else $error("table size above capacity");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == atns_pkg::STAT_EMPTY)
            |-> (rsp_alarm_count == '0) && !rsp_arm_valid)
        else $error("empty-table status with a non-empty table or an armed alarm");

    a_fail_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != atns_pkg::STAT_OK) |-> !rsp_arm_valid && !rsp_duplicate)
        else $error("failed command reports an arming or a duplicate");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_arm_index) && $stable(rsp_alarm_count))
        else $error("stalled response changed");

endmodule

bind alarm_table_next_alarm_scheduler atns_checker #(
    .MAX_ALARMS (MAX_ALARMS)
) u_atns_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_arm_valid   (rsp.arm_valid),
    .rsp_arm_index   (rsp.arm_index),
    .rsp_duplicate   (rsp.duplicate),
    .rsp_alarm_count (rsp.alarm_count)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for alarm_table_next_alarm_scheduler: directed and random
// table commands, checked against an in-bench model of the alarm table and scheduler.
// Depends on atns_pkg, atns_cmd_if, atns_rsp_if and the design files under design/.

module tb;
    import atns_pkg::*;

    localparam int SLOTS        = MAX_ALARMS_DEF;
    localparam int UNSET_SLOT   = NO_SLOT;
    localparam int RANDOM_ITEMS = 1600;
    localparam int IDLE_PCT     = 32;
    // In this window the sender never idles and the receiver never stalls.
    localparam int QUIET_FIRST  = 700;
    localparam int QUIET_LAST   = 1000;
    // A quiet tail longer than a full table search, so this covers any straggler.
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT  = 40;

    // Two copies of the table state: one that the stimulus generator advances while
    // it plans the command stream, and one that advances as transactions are accepted.
    localparam int PLAN = 0;
    localparam int LIVE = 1;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    atns_cmd_if cmd_ch ();
    atns_rsp_if rsp_ch ();

    alarm_table_next_alarm_scheduler uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Everything the bench drives starts at a known value before the first edge.
    logic drv_valid  = 1'b0;
    cmd_t drv_cmd    = '0;
    logic sink_ready = 1'b0;

    assign cmd_ch.valid          = drv_valid;
    assign cmd_ch.op             = drv_cmd.op;
    assign cmd_ch.entry_index    = drv_cmd.entry_index;
    assign cmd_ch.alarm_hour     = drv_cmd.alarm_hour;
    assign cmd_ch.alarm_minute   = drv_cmd.alarm_minute;
    assign cmd_ch.alarm_mode     = drv_cmd.alarm_mode;
    assign cmd_ch.alarm_weekmask = drv_cmd.alarm_weekmask;
    assign cmd_ch.now_hour       = drv_cmd.now_hour;
    assign cmd_ch.now_minute     = drv_cmd.now_minute;
    assign cmd_ch.now_weekday    = drv_cmd.now_weekday;
    assign rsp_ch.ready          = sink_ready;

    entry_t alarm_tbl [2][SLOTS];
    int     tbl_count [2];
    int     armed_slot [2];
    int     oneshot_slot [2];

    cmd_t cmd_queue [$];
    res_t due_rsp [$];

    res_t seen_rsp;
    res_t want_rsp;
    int   sent_cnt  = 0;
    int   got_cnt   = 0;
    int   error_cnt = 0;
    int   arm_cnt   = 0;
    int   dup_cnt   = 0;
    int   exp_cnt   = 0;
    int   full_cnt  = 0;
    int   empty_cnt = 0;

    // Applies one command to copy s of the table state and returns the response
    // that the block must give for it.
    function automatic res_t apply_alarm_cmd(input int s, input cmd_t c);
        res_t                  r;
        logic [KEY_W-1:0]      now_key;
        logic [KEY_W-1:0]      k;
        logic [KEY_W-1:0]      key_later;
        logic [KEY_W-1:0]      key_any;
        logic [MODE_W-1:0]     mode;
        logic [WEEKMASK_W-1:0] mask;
        int                    idx;
        int                    best_later;
        int                    best_any;
        int                    id;
        int                    p;
        r       = '0;
        now_key = {c.now_hour, c.now_minute};
        idx     = c.entry_index;
        case (c.op)
            OP_SET:
            begin
                // The index may address any live entry or the first free slot.
                if (idx > tbl_count[s] || idx >= SLOTS)
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    mode = c.alarm_mode;
                    mask = c.alarm_weekmask;
                    // An empty weekday mask means a one-shot for today.
                    if (mask == '0)
                    begin
                        mode = MODE_ONESHOT;
                        mask = WEEKMASK_W'(1 << c.now_weekday);
                    end
                    alarm_tbl[s][idx].hour     = c.alarm_hour;
                    alarm_tbl[s][idx].minute   = c.alarm_minute;
                    alarm_tbl[s][idx].mode     = mode;
                    alarm_tbl[s][idx].weekmask = mask;
                    if (idx == tbl_count[s])
                        tbl_count[s]++;
                end
            end
            OP_DEL:
            begin
                if (idx >= tbl_count[s])
                begin
                    r.status = STAT_RANGE;
                end
                else
                begin
                    // Armed and pending slot numbers are deliberately left alone.
                    for (int i = idx; i + 1 < tbl_count[s]; i++)
                        alarm_tbl[s][i] = alarm_tbl[s][i + 1];
                    tbl_count[s]--;
                end
            end
            OP_SCHED:
            begin
                if (tbl_count[s] == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    // Earliest entry strictly after now, else earliest of the day;
                    // strict compares keep ties on the lowest index.
                    best_later = UNSET_SLOT;
                    best_any   = 0;
                    key_later  = '0;
                    key_any    = {alarm_tbl[s][0].hour, alarm_tbl[s][0].minute};
                    for (int i = 0; i < tbl_count[s]; i++)
                    begin
                        k = {alarm_tbl[s][i].hour, alarm_tbl[s][i].minute};
                        if (k < key_any)
                        begin
                            key_any  = k;
                            best_any = i;
                        end
                        if (k > now_key && (best_later == UNSET_SLOT || k < key_later))
                        begin
                            key_later  = k;
                            best_later = i;
                        end
                    end
                    id             = (best_later != UNSET_SLOT) ? best_later : best_any;
                    r.arm_index    = INDEX_W'(id);
                    r.arm_hour     = alarm_tbl[s][id].hour;
                    r.arm_minute   = alarm_tbl[s][id].minute;
                    r.arm_weekmask = alarm_tbl[s][id].weekmask;
                    if (id != armed_slot[s])
                    begin
                        if (alarm_tbl[s][id].mode == MODE_REPEAT)
                        begin
                            r.arm_valid     = 1'b1;
                            oneshot_slot[s] = UNSET_SLOT;
                        end
                        else if (alarm_tbl[s][id].mode == MODE_ONESHOT)
                        begin
                            // Arming a one-shot consumes it.
                            r.arm_valid                = 1'b1;
                            oneshot_slot[s]            = id;
                            alarm_tbl[s][id].mode      = MODE_OFF;
                            alarm_tbl[s][id].weekmask  = '0;
                        end
                        armed_slot[s] = id;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < tbl_count[s]; i++)
                    if (i != idx && alarm_tbl[s][i].hour == c.alarm_hour
                        && alarm_tbl[s][i].minute == c.alarm_minute)
                        r.duplicate = 1'b1;
            end
        endcase
        p = oneshot_slot[s];
        if (p < SLOTS)
            if (now_key >= {alarm_tbl[s][p].hour, alarm_tbl[s][p].minute})
                r.one_shot_expired = 1'b1;
        r.alarm_count = COUNT_W'(tbl_count[s]);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        if (error_cnt < PRINT_LIMIT)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_cnt++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (got !== want)
            flag_error($sformatf("response %0d: %s is %0h, expected %0h",
                                 got_cnt, name, got, want));
    endtask

    // Queues one command and advances the planning copy so that later random
    // choices can see the table as it will be.
    task automatic add_cmd(input logic [OP_W-1:0] op, input int idx,
                           input int ah, input int am, input logic [MODE_W-1:0] amode,
                           input int amask, input int nh, input int nm, input int nwd);
        cmd_t c;
        c.op             = op;
        c.entry_index    = INDEX_W'(idx);
        c.alarm_hour     = HOUR_W'(ah);
        c.alarm_minute   = MINUTE_W'(am);
        c.alarm_mode     = amode;
        c.alarm_weekmask = WEEKMASK_W'(amask);
        c.now_hour       = HOUR_W'(nh);
        c.now_minute     = MINUTE_W'(nm);
        c.now_weekday    = WEEKDAY_W'(nwd);
        void'(apply_alarm_cmd(PLAN, c));
        cmd_queue.push_back(c);
    endtask

    // Times cluster on a few favorites and on times already in the table, so that
    // ties, duplicates, exact-time expiry and wrap-around all come up often.
    task automatic pick_time(output int h, output int m);
        int pool_h [5];
        int pool_m [5];
        int roll;
        int j;
        pool_h = '{0, 23, 12, 6, 18};
        pool_m = '{0, 59, 30, 0, 45};
        roll   = $urandom_range(99);
        if (roll < 35)
        begin
            j = $urandom_range(4);
            h = pool_h[j];
            m = pool_m[j];
        end
        else if (roll < 70 && tbl_count[PLAN] > 0)
        begin
            j = $urandom_range(tbl_count[PLAN] - 1);
            h = alarm_tbl[PLAN][j].hour;
            m = alarm_tbl[PLAN][j].minute;
            if ($urandom_range(2) == 0)
                m = (m == 59) ? 58 : m + 1;
        end
        else
        begin
            h = $urandom_range(23);
            m = $urandom_range(59);
        end
    endtask

    // Driver: a new transaction is presented when the channel is free, unless the
    // sender decides to idle this cycle. Each accepted transaction is run through
    // the live copy of the model to produce the response it is owed.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && cmd_ch.ready)
            begin
                due_rsp.push_back(apply_alarm_cmd(LIVE, drv_cmd));
                sent_cnt++;
            end
            if (!drv_valid || cmd_ch.ready)
            begin
                if (cmd_queue.size() > 0
                    && ((sent_cnt >= QUIET_FIRST && sent_cnt < QUIET_LAST)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    drv_cmd   <= cmd_queue.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: every response transaction is compared field by field with the
    // oldest response still owed; the receiver stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && sink_ready)
            begin
                seen_rsp.status           = rsp_ch.status;
                seen_rsp.arm_valid        = rsp_ch.arm_valid;
                seen_rsp.arm_index        = rsp_ch.arm_index;
                seen_rsp.arm_hour         = rsp_ch.arm_hour;
                seen_rsp.arm_minute       = rsp_ch.arm_minute;
                seen_rsp.arm_weekmask     = rsp_ch.arm_weekmask;
                seen_rsp.duplicate        = rsp_ch.duplicate;
                seen_rsp.one_shot_expired = rsp_ch.one_shot_expired;
                seen_rsp.alarm_count      = rsp_ch.alarm_count;
                if (due_rsp.size() == 0)
                begin
                    flag_error($sformatf("response %0d arrived with none outstanding",
                                         got_cnt));
                end
                else
                begin
                    want_rsp = due_rsp.pop_front();
                    cmp_field("status", want_rsp.status, seen_rsp.status);
                    cmp_field("arm_valid", want_rsp.arm_valid, seen_rsp.arm_valid);
                    cmp_field("arm_index", want_rsp.arm_index, seen_rsp.arm_index);
                    cmp_field("arm_hour", want_rsp.arm_hour, seen_rsp.arm_hour);
                    cmp_field("arm_minute", want_rsp.arm_minute, seen_rsp.arm_minute);
                    cmp_field("arm_weekmask", want_rsp.arm_weekmask,
                              seen_rsp.arm_weekmask);
                    cmp_field("duplicate", want_rsp.duplicate, seen_rsp.duplicate);
                    cmp_field("one_shot_expired", want_rsp.one_shot_expired,
                              seen_rsp.one_shot_expired);
                    cmp_field("alarm_count", want_rsp.alarm_count, seen_rsp.alarm_count);
                    arm_cnt   += want_rsp.arm_valid;
                    dup_cnt   += want_rsp.duplicate;
                    exp_cnt   += want_rsp.one_shot_expired;
                    full_cnt  += (want_rsp.alarm_count == SLOTS);
                    empty_cnt += (want_rsp.status == STAT_EMPTY);
                end
                got_cnt++;
            end
            sink_ready <= (got_cnt >= QUIET_FIRST && got_cnt < QUIET_LAST)
                          || $urandom_range(99) >= IDLE_PCT;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        logic [OP_W-1:0]     op;
        logic [MODE_W-1:0]   mode;
        int                  cnt;
        int                  idx;
        int                  roll;
        int                  ah;
        int                  am;
        int                  nh;
        int                  nm;
        int                  mask;
        bit                  growing;

        for (int s = 0; s < 2; s++)
        begin
            tbl_count[s]    = 0;
            armed_slot[s]   = UNSET_SLOT;
            oneshot_slot[s] = UNSET_SLOT;
            for (int i = 0; i < SLOTS; i++)
                alarm_tbl[s][i] = '0;
        end

        // Commands on an empty table: nothing to schedule, delete or match, and a
        // set that skips past the end of the table.
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 12, 0, 1);
        add_cmd(OP_DEL, 0, 0, 0, MODE_OFF, 0, 12, 0, 1);
        add_cmd(OP_DUP, 0, 0, 0, MODE_OFF, 0, 12, 0, 1);
        add_cmd(OP_SET, 1, 5, 5, MODE_REPEAT, 8'hFF, 12, 0, 1);
        // Extreme times, every mode including the unused code, and a zero mask
        // that turns a repeating entry into a one-shot on the last weekday.
        add_cmd(OP_SET, 0, 23, 59, MODE_REPEAT, 8'hFF, 12, 0, 1);
        add_cmd(OP_SET, 1, 0, 0, MODE_ONESHOT, 8'h01, 12, 0, 1);
        add_cmd(OP_SET, 2, 12, 30, MODE_SPARE, 8'h80, 12, 0, 1);
        add_cmd(OP_SET, 3, 12, 30, MODE_REPEAT, 0, 12, 0, 7);
        add_cmd(OP_SET, 4, 6, 0, MODE_OFF, 8'h55, 12, 0, 1);
        // Duplicate check that finds a twin, and one that only matches itself.
        add_cmd(OP_DUP, 2, 12, 30, MODE_OFF, 0, 12, 0, 1);
        add_cmd(OP_DUP, 0, 23, 59, MODE_OFF, 0, 12, 0, 1);
        // Tie on 12:30 goes to the lower slot, which holds the unused mode code,
        // so nothing is armed; asking again picks the same slot and does nothing.
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 12, 29, 1);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 12, 29, 1);
        // Nothing later than 23:59, so the search wraps to midnight and arms the
        // one-shot, which has expired at once; then an off entry and a repeater.
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 23, 59, 2);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 0, 0, 2);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 13, 0, 2);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 12, 0, 2);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 12, 30, 2);
        // Out-of-range set and delete, then delete the last and the first entry.
        add_cmd(OP_SET, 9, 1, 1, MODE_REPEAT, 8'h0F, 12, 0, 3);
        add_cmd(OP_DEL, 9, 0, 0, MODE_OFF, 0, 12, 0, 3);
        add_cmd(OP_DEL, 4, 0, 0, MODE_OFF, 0, 12, 0, 3);
        add_cmd(OP_DEL, 0, 0, 0, MODE_OFF, 0, 12, 0, 3);
        add_cmd(OP_SET, 1, 23, 59, MODE_REPEAT, 0, 12, 0, 1);
        add_cmd(OP_SCHED, 0, 0, 0, MODE_OFF, 0, 23, 58, 1);

        // Random part: the table alternately grows to full and shrinks to empty,
        // with schedules and duplicate checks mixed in throughout.
        growing = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cnt = tbl_count[PLAN];
            if (cnt == SLOTS)
                growing = 1'b0;
            else if (cnt == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 3)
                growing = !growing;

            roll = $urandom_range(99);
            if (roll < (growing ? 45 : 15))
                op = OP_SET;
            else if (roll < 55)
                op = OP_DEL;
            else if (roll < 82)
                op = OP_SCHED;
            else
                op = OP_DUP;

            if (op == OP_SET && cnt < SLOTS && $urandom_range(99) < (growing ? 70 : 25))
                idx = cnt;
            else if (cnt > 0 && $urandom_range(99) < 88)
                idx = $urandom_range(cnt - 1);
            else
                idx = $urandom_range(SLOTS - 1);

            roll = $urandom_range(99);
            if (roll < 15)
                mode = MODE_OFF;
            else if (roll < 50)
                mode = MODE_REPEAT;
            else if (roll < 85)
                mode = MODE_ONESHOT;
            else
                mode = MODE_SPARE;

            roll = $urandom_range(99);
            if (roll < 20)
                mask = 0;
            else if (roll < 30)
                mask = 8'hFF;
            else
                mask = $urandom_range(255);

            pick_time(ah, am);
            pick_time(nh, nm);
            add_cmd(op, idx, ah, am, mode, mask, nh, nm, $urandom_range(7, 1));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Every command sent, every response back, then a quiet tail in which
        // any extra response would be caught by the monitor.
        while (cmd_queue.size() > 0 || drv_valid)
            @(posedge clk);
        while (due_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands: %0d alarms armed, %0d duplicate hits, %0d expired one-shots.",
                 sent_cnt, arm_cnt, dup_cnt, exp_cnt);
        $display("Table was full in %0d responses, empty on %0d schedules; %0d mismatches.",
                 full_cnt, empty_cnt, error_cnt);
        if (error_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Far beyond the slowest legal run with every stall.
    initial
    begin
        #4_000_000;
        $display("Timed out with %0d commands sent and %0d responses seen.",
                 sent_cnt, got_cnt);
        $display("status: fail");
        $finish;
    end

endmodule

// ===== alarm_table_next_alarm_scheduler.f =====
design/atns_pkg.sv
design/atns_cmd_if.sv
design/atns_rsp_if.sv
design/atns_ram.sv
design/atns_scan.sv
design/alarm_table_next_alarm_scheduler.sv
design/atns_checker.sv
test/tb.sv
